// ----- hdl/pnm_hsp_pkg.sv -----
`timescale 1ns / 1ps

package pnm_hsp_pkg;

    // Header bytes with special meaning
    localparam logic [7:0] LF_BYTE    = 8'h0a;
    localparam logic [7:0] HASH_BYTE  = 8'h23;
    localparam logic [7:0] SPACE_BYTE = 8'h20;

    // Field widths
    localparam int unsigned ACC_W  = 25;
    localparam int unsigned DIM_W  = 24;
    localparam int unsigned LEN_W  = 16;
    localparam int unsigned DATA_W = 2 * DIM_W + LEN_W;
    localparam int unsigned USER_W = 2;

    // Line on which width and height are read
    localparam logic [1:0] DIM_LINE  = 2'd1;
    // Line feed count that ends the header
    localparam logic [1:0] END_LINE  = 2'd3;
    // Field index values
    localparam logic [1:0] FIELD_W   = 2'd0;
    localparam logic [1:0] FIELD_H   = 2'd1;
    localparam logic [1:0] FIELD_MAX = 2'd2;

    // Parameter defaults
    localparam int unsigned MAX_DIGITS_DEF = 8;
    localparam int unsigned COUNT_BITS_DEF = 16;

    // tuser bit positions on the result side
    localparam int unsigned USER_OVF_BIT  = 0;
    localparam int unsigned USER_DONE_BIT = 1;

    // Digit value of a header character; hex letters count 10..15, other bytes 0
    function automatic logic [3:0] char_value(input logic [7:0] b);
        logic [3:0] v;
        begin
            v = 4'd0;
            if (b >= 8'h30 && b <= 8'h39)
            begin
                v = 4'(b - 8'h30);
            end
            else if (b >= 8'h61 && b <= 8'h66)
            begin
                v = 4'(b - 8'h57);
            end
            else if (b >= 8'h41 && b <= 8'h46)
            begin
                v = 4'(b - 8'h37);
            end
            return v;
        end
    endfunction

endpackage

// ----- hdl/pnm_header_size_parser.sv -----
`timescale 1ns / 1ps

// Channel | dir | handshake                    | payload
// s_axis  | in  | s_axis_tvalid/s_axis_tready  | tdata[7:0] data_byte, tlast last_byte
// m_axis  | out | m_axis_tvalid/m_axis_tready  | tdata width/height/header_length,
//         |     |                              | tuser digits_overflow/header_complete
//
// One byte is accepted per cycle unless a byte that ends a header is waiting.
// Each byte goes through the input register, where the parser state is updated; a
// header result is loaded at that same edge into the output register that drives m_axis.
// rst_n clears the parser state and both valid flags.
// A stalled result holds m_axis; bytes that end nothing keep flowing, and a byte that
// ends a header waits in the input register until the output register is free.

module pnm_header_size_parser #(
    parameter int unsigned MAX_DIGITS = pnm_hsp_pkg::MAX_DIGITS_DEF,
    parameter int unsigned COUNT_BITS = pnm_hsp_pkg::COUNT_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [7:0]                        s_axis_tdata,  // [7:0] data_byte
    input  logic                              s_axis_tlast,  // last_byte
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [23:0] width, [47:24] height, [63:48] header_length
    output logic [pnm_hsp_pkg::DATA_W-1:0]    m_axis_tdata,
    // [0] digits_overflow, [1] header_complete
    output logic [pnm_hsp_pkg::USER_W-1:0]    m_axis_tuser
);

    localparam int unsigned DIG_W = $clog2(MAX_DIGITS + 1);
    localparam int unsigned ACC_W = pnm_hsp_pkg::ACC_W;
    localparam int unsigned DIM_W = pnm_hsp_pkg::DIM_W;
    localparam int unsigned LEN_W = pnm_hsp_pkg::LEN_W;
    localparam int unsigned EXT_W = COUNT_BITS + LEN_W;

    // Input register
    logic             in_valid_reg;
    logic [7:0]       in_byte_reg;
    logic             in_last_reg;

    // Parser state
    logic [1:0]       line_cnt_reg,   line_cnt_next;
    logic [1:0]       field_idx_reg,  field_idx_next;
    logic [ACC_W-1:0] width_acc_reg,  width_acc_next;
    logic [ACC_W-1:0] height_acc_reg, height_acc_next;
    logic [DIG_W-1:0] width_dig_reg,  width_dig_next;
    logic [DIG_W-1:0] height_dig_reg, height_dig_next;
    logic [COUNT_BITS-1:0] byte_cnt_reg, byte_cnt_next;

    // Output register
    logic             out_valid_reg;
    logic [DIM_W-1:0] out_width_reg;
    logic [DIM_W-1:0] out_height_reg;
    logic [LEN_W-1:0] out_len_reg;
    logic             out_ovf_reg;
    logic             out_done_reg;

    logic             complete;
    logic             emit;
    logic             advance;
    logic             ovf;
    logic [3:0]       digit;
    logic [EXT_W-1:0] cnt_ext;
    logic [LEN_W-1:0] len_sat;

    // Handshake: a byte that ends a header needs a free output register
    assign advance       = in_valid_reg && (!emit || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    // Per-byte parser update
    always_comb
    begin
        line_cnt_next   = line_cnt_reg;
        field_idx_next  = field_idx_reg;
        width_acc_next  = width_acc_reg;
        height_acc_next = height_acc_reg;
        width_dig_next  = width_dig_reg;
        height_dig_next = height_dig_reg;
        digit           = pnm_hsp_pkg::char_value(in_byte_reg);

        if (byte_cnt_reg != {COUNT_BITS{1'b1}})
        begin
            byte_cnt_next = byte_cnt_reg + 1'b1;
        end
        else
        begin
            byte_cnt_next = byte_cnt_reg;
        end

        priority if (in_byte_reg == pnm_hsp_pkg::LF_BYTE)
        begin
            line_cnt_next  = line_cnt_reg + 2'd1;
            field_idx_next = pnm_hsp_pkg::FIELD_W;
        end
        else if (in_byte_reg == pnm_hsp_pkg::HASH_BYTE)
        begin
            line_cnt_next = 2'd0;
        end
        else if (in_byte_reg == pnm_hsp_pkg::SPACE_BYTE)
        begin
            if (field_idx_reg < pnm_hsp_pkg::FIELD_MAX)
            begin
                field_idx_next = field_idx_reg + 2'd1;
            end
        end
        else
        begin
            // Dimension characters count only on the size line
            if (line_cnt_reg == pnm_hsp_pkg::DIM_LINE)
            begin
                if (field_idx_reg == pnm_hsp_pkg::FIELD_W)
                begin
                    if (width_dig_reg < DIG_W'(MAX_DIGITS - 1))
                    begin
                        width_acc_next = (width_acc_reg << 3) + (width_acc_reg << 1)
                                       + ACC_W'(digit);
                    end
                    if (width_dig_reg < DIG_W'(MAX_DIGITS))
                    begin
                        width_dig_next = width_dig_reg + 1'b1;
                    end
                end
                else if (field_idx_reg == pnm_hsp_pkg::FIELD_H)
                begin
                    if (height_dig_reg < DIG_W'(MAX_DIGITS - 1))
                    begin
                        height_acc_next = (height_acc_reg << 3) + (height_acc_reg << 1)
                                        + ACC_W'(digit);
                    end
                    if (height_dig_reg < DIG_W'(MAX_DIGITS))
                    begin
                        height_dig_next = height_dig_reg + 1'b1;
                    end
                end
            end
        end
    end

    // Result terms
    assign complete = (line_cnt_next == pnm_hsp_pkg::END_LINE);
    assign emit     = complete || in_last_reg;
    assign ovf      = (width_dig_next >= DIG_W'(MAX_DIGITS))
                   || (height_dig_next >= DIG_W'(MAX_DIGITS));
    assign cnt_ext  = {{LEN_W{1'b0}}, byte_cnt_next};
    assign len_sat  = (cnt_ext > EXT_W'({LEN_W{1'b1}})) ? {LEN_W{1'b1}}
                                                         : cnt_ext[LEN_W-1:0];

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_byte_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
    end

    // Parser state; a result restarts the parser
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_cnt_reg   <= '0;
            field_idx_reg  <= '0;
            width_acc_reg  <= '0;
            height_acc_reg <= '0;
            width_dig_reg  <= '0;
            height_dig_reg <= '0;
            byte_cnt_reg   <= '0;
        end
        else if (advance)
        begin
            if (emit)
            begin
                line_cnt_reg   <= '0;
                field_idx_reg  <= '0;
                width_acc_reg  <= '0;
                height_acc_reg <= '0;
                width_dig_reg  <= '0;
                height_dig_reg <= '0;
                byte_cnt_reg   <= '0;
            end
            else
            begin
                line_cnt_reg   <= line_cnt_next;
                field_idx_reg  <= field_idx_next;
                width_acc_reg  <= width_acc_next;
                height_acc_reg <= height_acc_next;
                width_dig_reg  <= width_dig_next;
                height_dig_reg <= height_dig_next;
                byte_cnt_reg   <= byte_cnt_next;
            end
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            out_width_reg  <= ovf ? '0 : width_acc_next[DIM_W-1:0];
            out_height_reg <= ovf ? '0 : height_acc_next[DIM_W-1:0];
            out_len_reg    <= len_sat;
            out_ovf_reg    <= ovf;
            out_done_reg   <= complete;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_len_reg, out_height_reg, out_width_reg};
    assign m_axis_tuser  = {out_done_reg, out_ovf_reg};

endmodule

// ----- hdl/pnm_hsp_checker.sv -----
`timescale 1ns / 1ps

module pnm_hsp_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [pnm_hsp_pkg::DATA_W-1:0] m_axis_tdata,
    input logic [pnm_hsp_pkg::USER_W-1:0] m_axis_tuser
);

    // A stalled result holds its payload
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // A fresh result follows an accepted byte through the input and output registers
    a_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
        else $error("result without a preceding byte");

    // Overflowed fields report zero width and height
    a_ovf_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[pnm_hsp_pkg::USER_OVF_BIT] |->
            m_axis_tdata[2*pnm_hsp_pkg::DIM_W-1:0] == '0)
        else $error("overflow with nonzero dimensions");

    // Every result counts at least its ending byte
    a_len: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[pnm_hsp_pkg::DATA_W-1:2*pnm_hsp_pkg::DIM_W] != '0)
        else $error("zero header length");

    // A complete header holds at least three line feeds
    a_done_len: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[pnm_hsp_pkg::USER_DONE_BIT] |->
            m_axis_tdata[pnm_hsp_pkg::DATA_W-1:2*pnm_hsp_pkg::DIM_W] >= 3)
        else $error("complete header shorter than three bytes");

endmodule

bind pnm_header_size_parser pnm_hsp_checker u_pnm_hsp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// ----- sim/pnm_header_size_parser_test.sv -----
`timescale 1ns / 1ps

module pnm_header_size_parser_test;

    localparam int unsigned CHAR_LIMIT = pnm_hsp_pkg::MAX_DIGITS_DEF;
    localparam int unsigned RANDOM_BYTES = 900;

    // One header result as seen on m_axis
    typedef struct packed {
        logic [pnm_hsp_pkg::DIM_W-1:0] width;
        logic [pnm_hsp_pkg::DIM_W-1:0] height;
        logic [pnm_hsp_pkg::LEN_W-1:0] hdr_len;
        logic                          ovf;
        logic                          done;
    } hdr_result_t;

    // Directed row: one byte, and optionally the result typed in by hand
    typedef struct packed {
        logic [7:0]  b;
        logic        last;
        logic        typed;
        hdr_result_t res;
    } step_row_t;

    localparam hdr_result_t NO_RES = '0;

    logic                              clk;
    logic                              rst_n;
    logic                              s_axis_tvalid;
    logic                              s_axis_tready;
    logic [7:0]                        s_axis_tdata;
    logic                              s_axis_tlast;
    logic                              m_axis_tvalid;
    logic                              m_axis_tready;
    logic [pnm_hsp_pkg::DATA_W-1:0]    m_axis_tdata;
    logic [pnm_hsp_pkg::USER_W-1:0]    m_axis_tuser;

    // Header parser state mirrored by the predictor
    logic [1:0]                        pred_lines;
    logic [1:0]                        pred_field;
    logic [pnm_hsp_pkg::ACC_W-1:0]     pred_w_acc;
    logic [pnm_hsp_pkg::ACC_W-1:0]     pred_h_acc;
    logic [3:0]                        pred_w_chars;
    logic [3:0]                        pred_h_chars;
    logic [pnm_hsp_pkg::LEN_W-1:0]     pred_bytes;

    hdr_result_t          expected_headers[$];
    logic [8:0]           header_text[$];     // {last, byte}
    step_row_t            directed_rows [25];

    int unsigned          mismatches;
    int unsigned          results_checked;
    int unsigned          complete_seen;
    int unsigned          overflow_seen;
    int unsigned          bytes_sent;
    int unsigned          tx_burst_left;
    bit                   tx_driving;
    int unsigned          rx_left;
    int unsigned          rx_pick;

    pnm_header_size_parser u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 clk = ~clk;

    // Digit weight of a dimension character; hex letters in either case
    function automatic logic [3:0] digit_of(input logic [7:0] b);
        if (b inside {[8'h30:8'h39]})
            return b[3:0];
        if (b inside {[8'h41:8'h46], [8'h61:8'h66]})
            return b[3:0] + 4'd9;
        return 4'd0;
    endfunction

    // Append one character to a dimension; value frozen past CHAR_LIMIT-1 chars
    function automatic void add_dim_char(inout logic [pnm_hsp_pkg::ACC_W-1:0] acc,
                                         inout logic [3:0] chars,
                                         input logic [7:0] b);
        if (chars < CHAR_LIMIT - 1)
            acc = acc * 25'd10 + pnm_hsp_pkg::ACC_W'(digit_of(b));
        if (chars < CHAR_LIMIT)
            chars = chars + 4'd1;
    endfunction

    function automatic void clear_parser();
        pred_lines   = '0;
        pred_field   = pnm_hsp_pkg::FIELD_W;
        pred_w_acc   = '0;
        pred_h_acc   = '0;
        pred_w_chars = '0;
        pred_h_chars = '0;
        pred_bytes   = '0;
    endfunction

    // Advance the header parser by one byte; returns 1 when a result is due
    function automatic bit header_step(input logic [7:0] b, input logic last,
                                       output hdr_result_t r);
        bit ended;
        bit ovf;
        r = '0;
        if (pred_bytes != '1)
            pred_bytes = pred_bytes + 1'b1;
        if (b == pnm_hsp_pkg::LF_BYTE)
        begin
            pred_lines = pred_lines + 2'd1;
            pred_field = pnm_hsp_pkg::FIELD_W;
        end
        else if (b == pnm_hsp_pkg::HASH_BYTE)
        begin
            pred_lines = '0;
        end
        else if (b == pnm_hsp_pkg::SPACE_BYTE)
        begin
            if (pred_field != pnm_hsp_pkg::FIELD_MAX)
                pred_field = pred_field + 2'd1;
        end
        else if (pred_lines == pnm_hsp_pkg::DIM_LINE)
        begin
            if (pred_field == pnm_hsp_pkg::FIELD_W)
                add_dim_char(pred_w_acc, pred_w_chars, b);
            else if (pred_field == pnm_hsp_pkg::FIELD_H)
                add_dim_char(pred_h_acc, pred_h_chars, b);
        end
        ended = (pred_lines == pnm_hsp_pkg::END_LINE);
        if (!ended && !last)
            return 1'b0;
        ovf = (pred_w_chars >= CHAR_LIMIT) || (pred_h_chars >= CHAR_LIMIT);
        r.width   = ovf ? '0 : pred_w_acc[pnm_hsp_pkg::DIM_W-1:0];
        r.height  = ovf ? '0 : pred_h_acc[pnm_hsp_pkg::DIM_W-1:0];
        r.hdr_len = pred_bytes;
        r.ovf     = ovf;
        r.done    = ended;
        clear_parser();
        return 1'b1;
    endfunction

    // Present one request on s_axis in bursts, predict once it is taken
    task automatic send_byte(input logic [7:0] b, input logic last, input logic typed,
                             input hdr_result_t typed_res);
        hdr_result_t r;
        if (tx_burst_left == 0)
        begin
            if (tx_driving)
            begin
                s_axis_tvalid <= 1'b0;
                tx_driving = 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            tx_burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 150)
                                                         : $urandom_range(1, 16);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        tx_driving = 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        tx_burst_left--;
        bytes_sent++;
        if (header_step(b, last, r))
            expected_headers.push_back(typed ? typed_res : r);
    endtask

    // Sender idles until every pending header result is back
    task automatic wait_for_results();
        if (tx_driving)
        begin
            s_axis_tvalid <= 1'b0;
            tx_driving = 1'b0;
        end
        @(posedge clk);
        while (expected_headers.size() != 0)
            @(posedge clk);
        tx_burst_left = 0;
    endtask

    task automatic push_char(input logic [7:0] b);
        header_text.push_back({1'b0, b});
    endtask

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        while (b == pnm_hsp_pkg::LF_BYTE || b == pnm_hsp_pkg::HASH_BYTE
               || b == pnm_hsp_pkg::SPACE_BYTE)
            b = 8'($urandom_range(0, 255));
        return b;
    endfunction

    function automatic logic [7:0] dim_char();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick < 7)
            return 8'h30 + 8'($urandom_range(0, 9));
        if (pick == 7)
            return 8'h61 + 8'($urandom_range(0, 5));
        if (pick == 8)
            return 8'h41 + 8'($urandom_range(0, 5));
        return plain_byte();
    endfunction

    task automatic add_field(input int unsigned n);
        repeat (n) push_char(dim_char());
    endtask

    // Comment line: '#', free text (may hold spaces and '#'), line feed
    task automatic add_comment();
        push_char(pnm_hsp_pkg::HASH_BYTE);
        repeat ($urandom_range(0, 10)) push_char(8'($urandom_range(8'h20, 8'h7e)));
        push_char(pnm_hsp_pkg::LF_BYTE);
    endtask

    function automatic int unsigned field_len();
        return ($urandom_range(0, 7) == 0) ? $urandom_range(6, 10) : $urandom_range(1, 5);
    endfunction

    // Well-formed header with random content, sometimes cut short
    task automatic build_header();
        int unsigned idx;
        push_char(8'h50);
        push_char(8'h31 + 8'($urandom_range(0, 6)));
        push_char(pnm_hsp_pkg::LF_BYTE);
        if ($urandom_range(0, 2) == 0)
            add_comment();
        add_field(field_len());
        push_char(pnm_hsp_pkg::SPACE_BYTE);
        if ($urandom_range(0, 9) == 0)
            push_char(pnm_hsp_pkg::SPACE_BYTE);
        add_field(field_len());
        if ($urandom_range(0, 4) == 0)
        begin
            push_char(pnm_hsp_pkg::SPACE_BYTE);
            add_field($urandom_range(1, 3));
        end
        push_char(pnm_hsp_pkg::LF_BYTE);
        if ($urandom_range(0, 5) == 0)
            add_comment();
        add_field($urandom_range(1, 5));
        push_char(pnm_hsp_pkg::LF_BYTE);
        if ($urandom_range(0, 9) == 0)
        begin
            // truncated file
            idx = $urandom_range(0, header_text.size() - 1);
            while (header_text.size() > idx + 1)
                void'(header_text.pop_back());
            header_text[idx] = {1'b1, header_text[idx][7:0]};
        end
        else if ($urandom_range(0, 11) == 0)
        begin
            idx = $urandom_range(0, header_text.size() - 1);
            header_text[idx] = {1'b1, header_text[idx][7:0]};
        end
    endtask

    // Noise biased toward the bytes the parser reacts to
    task automatic build_noise();
        int unsigned pick;
        repeat ($urandom_range(1, 24))
        begin
            pick = $urandom_range(0, 15);
            if (pick < 4)
                push_char(pnm_hsp_pkg::LF_BYTE);
            else if (pick < 6)
                push_char(pnm_hsp_pkg::SPACE_BYTE);
            else if (pick == 6)
                push_char(pnm_hsp_pkg::HASH_BYTE);
            else
                push_char(8'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 3) != 0)
            header_text[$] = {1'b1, header_text[$][7:0]};
    endtask

    task automatic send_text();
        logic [8:0] item;
        while (header_text.size() != 0)
        begin
            item = header_text.pop_front();
            send_byte(item[7:0], item[8], 1'b0, NO_RES);
        end
    endtask

    task automatic compare_field(input string name, input longint unsigned want,
                                 input longint unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    task automatic check_result();
        hdr_result_t want;
        hdr_result_t got;
        got.width   = m_axis_tdata[pnm_hsp_pkg::DIM_W-1:0];
        got.height  = m_axis_tdata[2*pnm_hsp_pkg::DIM_W-1:pnm_hsp_pkg::DIM_W];
        got.hdr_len = m_axis_tdata[pnm_hsp_pkg::DATA_W-1:2*pnm_hsp_pkg::DIM_W];
        got.ovf     = m_axis_tuser[pnm_hsp_pkg::USER_OVF_BIT];
        got.done    = m_axis_tuser[pnm_hsp_pkg::USER_DONE_BIT];
        if (expected_headers.size() == 0)
        begin
            $display("%0t: unexpected result, expected none, actual %h/%b",
                     $time, m_axis_tdata, m_axis_tuser);
            mismatches++;
            return;
        end
        want = expected_headers.pop_front();
        results_checked++;
        if (got.done)
            complete_seen++;
        if (got.ovf)
            overflow_seen++;
        compare_field("width", want.width, got.width);
        compare_field("height", want.height, got.height);
        compare_field("header_length", want.hdr_len, got.hdr_len);
        compare_field("digits_overflow", want.ovf, got.ovf);
        compare_field("header_complete", want.done, got.done);
    endtask

    // Result side: check on handshake, ready follows its own stall pattern
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
                check_result();
            if (rx_left == 0)
            begin
                rx_pick = $urandom_range(0, 9);
                if (rx_pick < 5)
                begin
                    m_axis_tready <= 1'b1;
                    rx_left = $urandom_range(1, 12);
                end
                else if (rx_pick < 9)
                begin
                    m_axis_tready <= 1'b0;
                    rx_left = $urandom_range(1, 8);
                end
                else
                begin
                    m_axis_tready <= 1'b1;
                    rx_left = $urandom_range(60, 200);
                end
            end
            else
            begin
                rx_left--;
            end
        end
    end

    // Run limit
    initial
    begin
        #25_000_000;
        $display("Timeout: header results still outstanding");
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        int unsigned random_bytes;
        bit          paused;
        clk           = 1'b0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        m_axis_tready = 1'b1;
        mismatches      = 0;
        results_checked = 0;
        complete_seen   = 0;
        overflow_seen   = 0;
        bytes_sent      = 0;
        tx_burst_left   = 0;
        tx_driving      = 1'b0;
        rx_left         = 0;
        random_bytes    = 0;
        paused          = 1'b0;
        clear_parser();

        directed_rows = '{
            // lone byte marked last right after reset
            '{8'h50, 1'b1, 1'b1, '{24'd0, 24'd0, 16'd1, 1'b0, 1'b0}},
            // mixed-case hex width, decimal height, bytes past height ignored
            '{8'h0a, 1'b0, 1'b0, NO_RES},
            '{8'h61, 1'b0, 1'b0, NO_RES},
            '{8'h46, 1'b0, 1'b0, NO_RES},
            '{8'h20, 1'b0, 1'b0, NO_RES},
            '{8'h39, 1'b0, 1'b0, NO_RES},
            '{8'h20, 1'b0, 1'b0, NO_RES},
            '{8'h20, 1'b0, 1'b0, NO_RES},
            '{8'h78, 1'b0, 1'b0, NO_RES},
            '{8'h0a, 1'b0, 1'b0, NO_RES},
            '{8'h0a, 1'b0, 1'b0, NO_RES},
            // eight-character width, then '#' and a final line feed
            '{8'h0a, 1'b0, 1'b0, NO_RES},
            '{8'hff, 1'b0, 1'b0, NO_RES},
            '{8'h00, 1'b0, 1'b0, NO_RES},
            '{8'h31, 1'b0, 1'b0, NO_RES},
            '{8'h32, 1'b0, 1'b0, NO_RES},
            '{8'h33, 1'b0, 1'b0, NO_RES},
            '{8'h34, 1'b0, 1'b0, NO_RES},
            '{8'h35, 1'b0, 1'b0, NO_RES},
            '{8'h36, 1'b0, 1'b0, NO_RES},
            '{8'h23, 1'b0, 1'b0, NO_RES},
            '{8'h0a, 1'b1, 1'b1, '{24'd0, 24'd0, 16'd11, 1'b1, 1'b0}},
            // third line feed carries the last flag
            '{8'h0a, 1'b0, 1'b0, NO_RES},
            '{8'h0a, 1'b0, 1'b0, NO_RES},
            '{8'h0a, 1'b1, 1'b1, '{24'd0, 24'd0, 16'd3, 1'b0, 1'b1}}
        };

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_byte(directed_rows[i].b, directed_rows[i].last, directed_rows[i].typed,
                      directed_rows[i].res);

        // random headers and noise, one full drain halfway through
        while (random_bytes < RANDOM_BYTES)
        begin
            if ($urandom_range(0, 9) < 7)
                build_header();
            else
                build_noise();
            random_bytes += header_text.size();
            send_text();
            if (!paused && random_bytes >= RANDOM_BYTES / 2)
            begin
                wait_for_results();
                paused = 1'b1;
            end
        end

        wait_for_results();
        repeat (10) @(posedge clk);

        $display("Sent %0d bytes: directed headers and %0d random header and noise bytes",
                 bytes_sent, random_bytes);
        $display("Checked %0d results: %0d complete headers, %0d with digit overflow",
                 results_checked, complete_seen, overflow_seen);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
